[sv/tfr_pkg.sv]
package tfr_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] SUM_TARGET  = 8'hFF;
    localparam logic [7:0] KIND_MIN    = 8'd1;
    localparam logic [7:0] KIND_MAX    = 8'd10;

    // One queued result: everything the output side needs for one payload byte.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] payload;
        logic [3:0] index;
        logic       last;
    } entry_t;

    // Parser to queue: a tentative write, and the verdict on the frame.
    typedef struct packed {
        logic   wr_en;
        logic   commit;
        logic   abort;
        entry_t entry;
    } wr_ctl_t;

    // Fixed frame length of each type; zero marks a type that does not exist.
    function automatic logic [3:0] kind_length(input logic [3:0] kind);
        logic [3:0] len;
        unique case (kind)
            4'd1:    len = 4'd8;
            4'd2:    len = 4'd3;
            4'd3:    len = 4'd3;
            4'd4:    len = 4'd3;
            4'd5:    len = 4'd3;
            4'd6:    len = 4'd3;
            4'd7:    len = 4'd3;
            4'd8:    len = 4'd3;
            4'd9:    len = 4'd14;
            4'd10:   len = 4'd3;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

[sv/tfr_front.sv]
module tfr_front
    import tfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       queue_full,
    output wr_ctl_t    wr
);

    typedef enum logic [4:0] {
        ST_HUNT  = 5'b00001,
        ST_KIND  = 5'b00010,
        ST_LEN   = 5'b00100,
        ST_DATA  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] kind_reg, kind_next;
    logic [3:0] taken_reg, taken_next;
    logic [7:0] sum_reg, sum_next;

    logic [3:0] len;
    logic       accept;
    logic       data_done;

    assign len       = kind_length(kind_reg);
    // Payload bytes wait only when the queue has no room for them.
    assign in_ready  = !((state_reg == ST_DATA) && queue_full);
    assign accept    = in_valid && in_ready;
    assign data_done = ({1'b0, taken_reg} + 5'd2) >= {1'b0, len};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        taken_next     = taken_reg;
        sum_next       = sum_reg;
        wr.wr_en       = 1'b0;
        wr.commit      = 1'b0;
        wr.abort       = 1'b0;
        wr.entry.kind    = kind_reg;
        wr.entry.payload = in_byte;
        wr.entry.index   = taken_reg;
        wr.entry.last    = data_done;
        if (accept)
        begin
            unique case (state_reg)
                ST_KIND:
                begin
                    if ((in_byte >= KIND_MIN) && (in_byte <= KIND_MAX))
                    begin
                        kind_next  = in_byte[3:0];
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_LEN:
                begin
                    if ((len != 4'd0) && (in_byte == {4'd0, len}))
                    begin
                        taken_next = 4'd0;
                        sum_next   = {4'd0, kind_reg} + {4'd0, len};
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_DATA:
                begin
                    wr.wr_en   = 1'b1;
                    taken_next = taken_reg + 4'd1;
                    sum_next   = sum_reg + in_byte;
                    if (data_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if ((sum_reg + in_byte) == SUM_TARGET)
                    begin
                        wr.commit = 1'b1;
                    end
                    else
                    begin
                        wr.abort = 1'b1;
                    end
                    taken_next = 4'd0;
                    state_next = ST_HUNT;
                end
                default:
                begin
                    state_next = (in_byte == HEADER_BYTE) ? ST_KIND : ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            kind_reg  <= 4'd0;
            taken_reg <= 4'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[sv/tfr_queue.sv]
module tfr_queue
    import tfr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  wr_ctl_t wr,
    output logic    full,
    output logic    avail,
    input  logic    pop,
    output entry_t  rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] commit_ptr_reg, commit_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] used_reg, used_next;
    logic [3:0]    tent_reg, tent_next;
    entry_t        rd_data_reg;

    // Entries written since the last verdict are tentative: visible to the
    // parser's fill level but not to the reader until the frame is committed.
    assign full    = (used_reg == FULL_CNT);
    assign avail   = (used_reg != CW'(tent_reg));
    assign rd_data = rd_data_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        rd_ptr_next     = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        tent_next       = tent_reg;
        used_next       = used_reg + CW'(wr.wr_en) - CW'(pop);
        if (wr.wr_en)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            tent_next   = tent_reg + 4'd1;
        end
        if (wr.commit)
        begin
            commit_ptr_next = wr_ptr_reg;
            tent_next       = 4'd0;
        end
        if (wr.abort)
        begin
            wr_ptr_next = commit_ptr_reg;
            tent_next   = 4'd0;
            used_next   = used_reg - CW'(tent_reg) - CW'(pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            commit_ptr_reg <= '0;
            rd_ptr_reg     <= '0;
            used_reg       <= '0;
            tent_reg       <= 4'd0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            used_reg       <= used_next;
            tent_reg       <= tent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr_ptr_reg] <= wr.entry;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    a_no_write_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        wr.wr_en |-> !full)
        else $error("payload write into a full queue");

    a_pop_only_committed : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> avail)
        else $error("read of an entry that is not committed");

    a_tent_within_used : assert property (@(posedge clk) disable iff (!rst_n)
        CW'(tent_reg) <= used_reg)
        else $error("tentative count exceeds queue fill");

    a_verdict_clears_tent : assert property (@(posedge clk) disable iff (!rst_n)
        (wr.commit || wr.abort) |=> (tent_reg == 4'd0))
        else $error("tentative entries left after frame verdict");

endmodule

[sv/tfr_back.sv]
module tfr_back
    import tfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   avail,
    output logic   pop,
    input  entry_t rd_data,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    logic   pend_reg;
    logic   out_valid_reg;
    entry_t out_entry_reg;
    logic   out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    // Read ahead only when the output register will be free once the data lands.
    assign pop       = avail && !pend_reg && (!out_valid_reg || out_fire);
    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pop;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_entry_reg <= rd_data;
        end
    end

endmodule

[sv/typed_frame_receiver.sv]
// Channel   | Direction | Signals                         | Contents
// ----------+-----------+---------------------------------+-------------------------------------
// s_axis    | in        | tvalid, tready, tdata[7:0]      | rx_byte
// m_axis    | out       | tvalid, tready, tdata[15:0],    | tdata: payload_byte, byte_index,
//           |           | tuser[3:0], tlast               | zero pad; tuser: frame_kind;
//           |           |                                 | tlast: last_byte
//
// The input side takes one byte per cycle. It stalls only on payload bytes,
// and only while the result queue holds MAX_PAYLOAD entries.
// Results leave through a registered queue read that feeds the output register;
// a new queue read does not start while the previous one is still landing.
// Reset is asynchronous and active low; the parser returns to the header hunt
// and the queue empties. The queue memory itself is not cleared.
// Output stalls back up into the queue, and into the input only on payload bytes;
// the parser keeps taking header, type, length and checksum bytes regardless.
module typed_frame_receiver
    import tfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] byte_index, [15:12] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] frame_kind
    output logic        m_axis_tlast
);

    // Front end: the parser checks header, type, length and checksum, and writes
    // each payload byte into the queue tentatively as it arrives.
    wr_ctl_t wr;
    logic    queue_full;
    logic    queue_avail;
    logic    pop;
    entry_t  rd_data;
    entry_t  out_entry;

    tfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .queue_full (queue_full),
        .wr         (wr)
    );

    // A good checksum commits the frame's entries to the reader; a bad one
    // rolls the write pointer back so the frame is never seen.
    tfr_queue #(
        .DEPTH (MAX_PAYLOAD)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .full    (queue_full),
        .avail   (queue_avail),
        .pop     (pop),
        .rd_data (rd_data)
    );

    // Back end: drains committed entries into the output register.
    tfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (queue_avail),
        .pop       (pop),
        .rd_data   (rd_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry)
    );

    assign m_axis_tdata = {4'd0, out_entry.index, out_entry.payload};
    assign m_axis_tuser = out_entry.kind;
    assign m_axis_tlast = out_entry.last;

endmodule

[bench/frame_checker.sv]
// Watches both channels of the frame receiver. It parses every accepted input
// byte with its own copy of the parser state. It queues the payload results
// that a validated frame must produce, and compares each output transaction
// against the oldest one.
module frame_checker
    import tfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        drain_check,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        SEEK_HEADER,
        WANT_KIND,
        WANT_LEN,
        TAKE_DATA,
        WANT_SUM
    } parse_phase_t;

    // Frame length per type, four bits each, type 0 in the lowest nibble.
    localparam logic [63:0] LEN_TABLE = {
        {5{4'd0}}, 4'd3, 4'd14, {7{4'd3}}, 4'd8, 4'd0
    };

    parse_phase_t phase;
    logic [3:0]   cur_kind;
    logic [3:0]   taken;
    logic [7:0]   sum;
    logic [7:0]   stash [0:15];
    entry_t       payload_due [$];
    logic         drained;
    int           shown;

    function automatic logic [3:0] frame_len(input logic [3:0] kind);
        return LEN_TABLE[{kind, 2'b00} +: 4];
    endfunction

    task automatic note_error(input string msg);
        if (shown < 30)
            $display("ERROR at %0t: %s", $time, msg);
        shown++;
        fail_count++;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [3:0] len;
        logic [7:0] total;
        entry_t     e;
        len = frame_len(cur_kind);
        total = sum + b;
        case (phase)
            WANT_KIND:
            begin
                if (b >= KIND_MIN && b <= KIND_MAX)
                begin
                    cur_kind = b[3:0];
                    phase = WANT_LEN;
                end
                else
                    phase = SEEK_HEADER;
            end
            WANT_LEN:
            begin
                if (len != 4'd0 && b == {4'd0, len})
                begin
                    taken = 4'd0;
                    sum = {4'd0, cur_kind} + {4'd0, len};
                    phase = TAKE_DATA;
                end
                else
                    phase = SEEK_HEADER;
            end
            TAKE_DATA:
            begin
                // The length counts the checksum byte, so one byte less is payload.
                if ({1'b0, taken} + 5'd1 < {1'b0, len})
                begin
                    stash[taken] = b;
                    sum = sum + b;
                    taken = taken + 4'd1;
                end
                if ({1'b0, taken} + 5'd1 >= {1'b0, len})
                    phase = WANT_SUM;
            end
            WANT_SUM:
            begin
                if (total == SUM_TARGET)
                begin
                    for (int k = 0; k < taken; k++)
                    begin
                        e.kind = cur_kind;
                        e.payload = stash[k];
                        e.index = k[3:0];
                        e.last = (k + 1 == taken);
                        payload_due.push_back(e);
                    end
                end
                taken = 4'd0;
                phase = SEEK_HEADER;
            end
            default:
                phase = (b == HEADER_BYTE) ? WANT_KIND : SEEK_HEADER;
        endcase
    endtask

    task automatic check_result();
        entry_t want;
        if (payload_due.size() == 0)
        begin
            note_error($sformatf("unexpected result kind %0d byte %02h index %0d last %0b",
                                 m_tuser, m_tdata[7:0], m_tdata[11:8], m_tlast));
            return;
        end
        want = payload_due.pop_front();
        if (m_tuser != want.kind)
            note_error($sformatf("frame kind %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata[7:0] != want.payload)
            note_error($sformatf("payload byte %02h, expected %02h", m_tdata[7:0],
                                 want.payload));
        if (m_tdata[11:8] != want.index)
            note_error($sformatf("byte index %0d, expected %0d", m_tdata[11:8], want.index));
        if (m_tlast != want.last)
            note_error($sformatf("last flag %0b, expected %0b at index %0d", m_tlast,
                                 want.last, want.index));
        if (m_tdata[15:12] != 4'd0)
            note_error($sformatf("pad bits %h, expected zero", m_tdata[15:12]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = SEEK_HEADER;
            cur_kind = 4'd0;
            taken = 4'd0;
            sum = 8'd0;
            payload_due.delete();
            drained = 1'b0;
            shown = 0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (drain_check && !drained)
            begin
                drained = 1'b1;
                while (payload_due.size() > 0)
                begin
                    note_error($sformatf("result never arrived: kind %0d index %0d",
                                         payload_due[0].kind, payload_due[0].index));
                    void'(payload_due.pop_front());
                end
            end
            pending = payload_due.size();
        end
    end

endmodule

[bench/tb.sv]
// Stimulus and verdict for the frame receiver. The sender streams serial bytes
// in bursts. The receiver stalls on a pattern of its own, with long hold-offs
// that fill the result queue and back up into the input. The checker beside
// the block does all prediction and comparison.
module tb
    import tfr_pkg::*;
();

    typedef enum int {
        INTACT,
        BAD_SUM,
        BAD_LEN,
        CUT_SHORT
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tready = 1'b0;
    logic        drain_check = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire  [3:0]  m_axis_tuser;
    wire         m_axis_tlast;
    int          fail_count;
    int          pending;
    int          sent = 0;
    int          burst_left = 0;

    always #4 clk = ~clk;

    typed_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    frame_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .drain_check (drain_check),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Offers one byte and returns at the edge where the transaction completes.
    // A new burst starts with a random gap, which is often zero.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? 0
                : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // Holds the input idle until the checker has seen every expected result.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_frame(input logic [3:0] kind, input flaw_t flaw);
        int         count;
        int         cut;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] p;
        logic [7:0] chk;
        count = (kind == 4'd1) ? 7 : (kind == 4'd9) ? 13 : 2;
        len = 8'(count + 1);
        sum = {4'd0, kind} + len;
        put_byte(HEADER_BYTE);
        put_byte({4'd0, kind});
        // A wrong length still sends the body, which the parser must skip.
        put_byte(flaw == BAD_LEN ? 8'(len + $urandom_range(1, 255)) : len);
        cut = (flaw == CUT_SHORT) ? $urandom_range(0, count - 1) : count;
        for (int i = 0; i < cut; i++)
        begin
            p = 8'($urandom);
            sum = sum + p;
            put_byte(p);
        end
        if (flaw == CUT_SHORT)
            return;
        chk = SUM_TARGET - sum;
        if (flaw == BAD_SUM)
            chk = chk ^ 8'($urandom_range(1, 255));
        put_byte(chk);
    endtask

    // Receiver: segments of steady, random or sparse readiness, and every
    // sixth segment a long hold-off while the sender keeps going.
    initial
    begin
        int mode;
        int seg_len;
        @(posedge rst_n);
        for (int seg = 0; ; seg++)
        begin
            if (seg % 6 == 2)
            begin
                for (int i = 0; i < 250; i++)
                begin
                    @(posedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 2);
                seg_len = $urandom_range(10, 80);
                for (int i = 0; i < seg_len; i++)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [7:0] opening_q [$];
        int         pick;
        int         spins;
        bit         paused_mid;
        // Type zero, a repeated header, type eleven, a length mismatch,
        // a bad checksum with extreme payload, then a good type 10 frame.
        opening_q = '{HEADER_BYTE, 8'h00,
                      HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, 8'h0B,
                      HEADER_BYTE, 8'h02, 8'h04,
                      HEADER_BYTE, 8'h03, 8'h03, 8'h00, 8'hFF, 8'hFB,
                      HEADER_BYTE, 8'h0A, 8'h03, 8'hFF, 8'h00, 8'hF3};
        paused_mid = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_q[i])
            put_byte(opening_q[i]);
        wait_for_results();

        while (sent < 370)
        begin
            if (!paused_mid && sent >= 200)
            begin
                wait_for_results();
                paused_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(4'($urandom_range(1, 10)), INTACT);
            else if (pick < 80)
                send_frame(4'($urandom_range(1, 10)), BAD_SUM);
            else if (pick < 85)
                send_frame(4'($urandom_range(1, 10)), BAD_LEN);
            else if (pick < 90)
                send_frame(4'($urandom_range(1, 10)), CUT_SHORT);
            else if (pick < 95)
            begin
                put_byte(HEADER_BYTE);
                put_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(11, 255)));
            end
            else
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        spins = 0;
        @(negedge clk);
        while (pending != 0 && spins < 20000)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (40) @(posedge clk);
        drain_check <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
